// ===== rtl/csfa_pkg.sv =====
// ----------------------------------------------------------------------------
// csfa_pkg
// shared types, register map and constants of the current sensor frame averager
// ----------------------------------------------------------------------------
package csfa_pkg;

  localparam int WORD_W     = 16;
  localparam int RAW_W      = 13;
  localparam int SUM_W      = 19;
  localparam int CNT_W      = 6;
  localparam int GAIN_W     = 10;
  localparam int MA_W       = 24;
  localparam int DIFF_W     = RAW_W + 1;
  localparam int RECIP_W    = 21;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam int SAMPLES_DEF    = 8;
  localparam int FIFO_DEPTH_DEF = 8;

  localparam logic [RAW_W-1:0]  OFFSET_RST = 13'd4096;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 10'd125;

  localparam logic [1:0] REG_NORMAL_ID = 2'd0;
  localparam logic [1:0] REG_OFFSET    = 2'd1;
  localparam logic [1:0] REG_GAIN      = 2'd2;

  typedef struct packed {
    logic              normal_id_bit;
    logic [RAW_W-1:0]  current_offset;
    logic [GAIN_W-1:0] ma_per_lsb;
  } cfg_t;

  typedef struct packed {
    logic signed [MA_W-1:0] current_ma;
    logic [WORD_W-1:0]      status_word;
  } result_t;

endpackage

// ===== rtl/current_sensor_frame_averager.sv =====
// ----------------------------------------------------------------------------
// a completing frame beat passes the input, result, quotient and product stages
// throughput: one frame beat per cycle, one result beat per SAMPLES frames
// the result queue holds FIFO_DEPTH beats; sample_ready drops while that many
// frames and results are in flight or waiting
// reset (rst, synchronous): held value, status latch, sum and count cleared,
// registers back to id 0, offset 4096, 125 ma per code
// ----------------------------------------------------------------------------
// current_sensor_frame_averager
// parity-checked sensor frames summed over a window, scaled to milliamps
// ----------------------------------------------------------------------------
module current_sensor_frame_averager #(
  parameter int SAMPLES    = csfa_pkg::SAMPLES_DEF,
  parameter int FIFO_DEPTH = csfa_pkg::FIFO_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [csfa_pkg::APB_AW-1:0]        paddr,
  input  logic [csfa_pkg::APB_DW-1:0]        pwdata,
  output logic [csfa_pkg::APB_DW-1:0]        prdata,
  output logic                               pready,
  input  logic                               sample_valid,
  output logic                               sample_ready,
  input  logic [csfa_pkg::WORD_W-1:0]        sample_word,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic signed [csfa_pkg::MA_W-1:0]   current_ma,
  output logic [csfa_pkg::WORD_W-1:0]        status_word
);
  import csfa_pkg::*;

  localparam int RECIP_SHIFT = SUM_W + $clog2(SAMPLES);
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
  localparam int UW = $clog2(FIFO_DEPTH + 1);
  localparam int QP_W = SUM_W + RECIP_W;

  cfg_t cfg;

  csfa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // flow control
  logic          in_fire;
  logic          out_fire;
  logic          drop;
  logic [UW-1:0] used;
  logic [UW-1:0] used_next;

  // input stage
  logic              in_v;
  logic [WORD_W-1:0] in_word;

  // frame state
  logic [RAW_W-1:0]  held_raw;
  logic [WORD_W-1:0] error_latch;
  logic [SUM_W-1:0]  sum_acc;
  logic [CNT_W-1:0]  frame_count;

  logic              is_cur;
  logic              cur_ok;
  logic              stat_ok;
  logic [RAW_W-1:0]  held_next;
  logic [WORD_W-1:0] error_next;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W:0]    count_inc;
  logic              last;

  // window result, quotient, product stages
  logic              res_v;
  logic [SUM_W-1:0]  res_sum;
  logic [WORD_W-1:0] res_err;
  logic [QP_W-1:0]   quot_prod;
  logic              q_v;
  logic [RAW_W-1:0]  q_avg;
  logic [WORD_W-1:0] q_err;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [DIFF_W+GAIN_W:0] ma_prod;
  logic              p_v;
  result_t           p_res;
  result_t           out_res;

  assign in_fire      = sample_valid && sample_ready;
  assign out_fire     = result_valid && result_ready;
  assign sample_ready = (used != UW'(FIFO_DEPTH));
  assign drop         = in_v && !last;

  always_comb begin
    used_next = used;
    if (in_fire) used_next = used_next + UW'(1);
    if (drop) used_next = used_next - UW'(1);
    if (out_fire) used_next = used_next - UW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      in_v <= 1'b0;
    end else begin
      used <= used_next;
      in_v <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_word <= sample_word;
    end
  end

  // parity bit is 1 for an even count of ones
  always_comb begin
    is_cur     = (in_word[WORD_W-1] == cfg.normal_id_bit);
    cur_ok     = (in_word[14] == ~^in_word[RAW_W-1:0]);
    stat_ok    = (in_word[14] == ~^in_word);
    held_next  = held_raw;
    error_next = error_latch;
    if (is_cur) begin
      if (cur_ok) begin
        held_next  = in_word[RAW_W-1:0];
        error_next = '0;
      end
    end else if (stat_ok) begin
      error_next = in_word;
    end
    sum_next  = sum_acc + SUM_W'(held_next);
    count_inc = {1'b0, frame_count} + (CNT_W+1)'(1);
    last      = (count_inc >= (CNT_W+1)'(SAMPLES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_raw    <= '0;
      error_latch <= '0;
      sum_acc     <= '0;
      frame_count <= '0;
      res_v       <= 1'b0;
      q_v         <= 1'b0;
      p_v         <= 1'b0;
    end else begin
      res_v <= in_v && last;
      q_v   <= res_v;
      p_v   <= q_v;
      if (in_v) begin
        held_raw    <= held_next;
        error_latch <= error_next;
        if (last) begin
          sum_acc     <= '0;
          frame_count <= '0;
        end else begin
          sum_acc     <= sum_next;
          frame_count <= count_inc[CNT_W-1:0];
        end
      end
    end
  end

  // divide by SAMPLES through a reciprocal, exact over the sum range
  assign quot_prod = QP_W'(res_sum) * QP_W'(RECIP);
  assign diff      = $signed({1'b0, q_avg}) - $signed({1'b0, cfg.current_offset});
  assign ma_prod   = diff * $signed({1'b0, cfg.ma_per_lsb});

  always_ff @(posedge clk) begin
    res_sum           <= sum_next;
    res_err           <= error_next;
    q_avg             <= quot_prod[RECIP_SHIFT +: RAW_W];
    q_err             <= res_err;
    p_res.current_ma  <= ma_prod[MA_W-1:0];
    p_res.status_word <= q_err;
  end

  csfa_res_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (p_v),
    .wdata     (p_res),
    .pop       (result_ready),
    .not_empty (result_valid),
    .rdata     (out_res)
  );

  assign current_ma  = out_res.current_ma;
  assign status_word = out_res.status_word;

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(FIFO_DEPTH))
    else $error("more beats in flight than the result queue holds");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, frame_count} < (CNT_W+1)'(SAMPLES))
    else $error("frame count outside the window");

  a_result_flows: assert property (@(posedge clk) disable iff (rst)
    res_v |=> q_v ##1 p_v)
    else $error("window result lost in the scaling pipeline");

  a_out_has_credit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> used != '0)
    else $error("result beat without a counted entry");

endmodule

// ===== rtl/csfa_cfg.sv =====
// ----------------------------------------------------------------------------
// csfa_cfg
// apb register bank: id bit, zero-current offset and gain
// ----------------------------------------------------------------------------
module csfa_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [csfa_pkg::APB_AW-1:0] paddr,
  input  logic [csfa_pkg::APB_DW-1:0] pwdata,
  output logic [csfa_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output csfa_pkg::cfg_t              cfg
);
  import csfa_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_id_bit  <= 1'b0;
      cfg.current_offset <= OFFSET_RST;
      cfg.ma_per_lsb     <= GAIN_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_NORMAL_ID: cfg.normal_id_bit  <= pwdata[0];
        REG_OFFSET:    cfg.current_offset <= pwdata[RAW_W-1:0];
        REG_GAIN:      cfg.ma_per_lsb     <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NORMAL_ID: prdata = {{(APB_DW-1){1'b0}}, cfg.normal_id_bit};
      REG_OFFSET:    prdata = {{(APB_DW-RAW_W){1'b0}}, cfg.current_offset};
      REG_GAIN:      prdata = {{(APB_DW-GAIN_W){1'b0}}, cfg.ma_per_lsb};
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/csfa_res_fifo.sv =====
// ----------------------------------------------------------------------------
// csfa_res_fifo
// small result queue that decouples the pipeline from the output handshake
// ----------------------------------------------------------------------------
module csfa_res_fifo #(
  parameter int DEPTH = csfa_pkg::FIFO_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  csfa_pkg::result_t wdata,
  input  logic              pop,
  output logic              not_empty,
  output csfa_pkg::result_t rdata
);
  import csfa_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  result_t         mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            do_pop;

  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign rdata     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_comb begin
    count_next = count;
    if (push) count_next = count_next + CW'(1);
    if (do_pop) count_next = count_next - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
    end
  end

endmodule
